FILE: rtl/core/lpog_pkg.sv
// Shared constants, cell codes, command codes and control structs for the occupancy grid.
package lpog_pkg;

    // Default grid geometry
    localparam int HALF_CELLS_DEF = 55;
    localparam int CELL_MM_DEF    = 100;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 16;
    localparam int ADDR_W  = 14;
    localparam int VALUE_W = 7;
    localparam int CODE_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GRASS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ROAD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    // Stored cell codes
    localparam logic [CODE_W-1:0] CELL_UNKNOWN = 2'd0;
    localparam logic [CODE_W-1:0] CELL_ROAD    = 2'd1;
    localparam logic [CODE_W-1:0] CELL_GRASS   = 2'd2;

    // Occupancy values seen on the result channel
    localparam logic signed [VALUE_W-1:0] VAL_UNKNOWN = -7'sd1;
    localparam logic signed [VALUE_W-1:0] VAL_ROAD    = 7'sd0;
    localparam logic signed [VALUE_W-1:0] VAL_GRASS   = 7'sd50;

    typedef logic [CMD_W-1:0]  t_cmd;
    typedef logic [CODE_W-1:0] t_code;

    // Controller to datapath
    typedef struct packed {
        logic in_rdy;      // take a transfer on the input channel
        logic sweep_step;  // write unknown at the sweep pointer and advance
        logic coord;       // register range check and scaled coordinates
        logic mul;         // multiply by the reciprocal of twice the cell pitch
        logic index;       // form the row-major cell index
        logic rd;          // read the addressed cell
        logic wb;          // update the cell and load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic in_read;
        logic in_extent;   // held point lies within the grid extent
        logic sweep_last;
        logic out_free;    // result register can take a new result this cycle
    } t_dp_sts;

    function automatic logic signed [VALUE_W-1:0] code_value(input t_code code);
        logic signed [VALUE_W-1:0] v;
        case (code)
            CELL_ROAD:  v = VAL_ROAD;
            CELL_GRASS: v = VAL_GRASS;
            default:    v = VAL_UNKNOWN;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/lpog_if.sv
// Valid/ready channel interfaces for grid commands and grid results.
interface lpog_in_if import lpog_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] point_x_mm;
    logic signed [COORD_W-1:0] point_y_mm;
    logic [ADDR_W-1:0]         read_index;

    modport source (output valid, cmd, point_x_mm, point_y_mm, read_index, input ready);
    modport sink   (input valid, cmd, point_x_mm, point_y_mm, read_index, output ready);
endinterface

interface lpog_out_if import lpog_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] cell_value;
    logic [ADDR_W-1:0]         cell_addr;
    logic                      point_dropped;

    modport source (output valid, cell_value, cell_addr, point_dropped, input ready);
    modport sink   (input valid, cell_value, cell_addr, point_dropped, output ready);
endinterface

FILE: rtl/core/lpog_ctrl.sv
// Sequencer for clear sweeps, point binning and cell reads.
module lpog_ctrl import lpog_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COORD = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_INDEX = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;
    localparam logic [2:0] S_WB    = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_sweep_rsp, n_sweep_rsp;

    always_comb begin
        n_state     = r_state;
        n_sweep_rsp = r_sweep_rsp;
        o_cmd       = '0;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state     = r_sweep_rsp ? S_WB : S_IDLE;
                    n_sweep_rsp = 1'b0;
                end
            end
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_sts.in_valid) begin
                    if (i_sts.in_clear) begin
                        n_state     = S_SWEEP;
                        n_sweep_rsp = 1'b1;
                    end else if (i_sts.in_read) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_COORD;
                    end
                end
            end
            S_COORD: begin
                o_cmd.coord = 1'b1;
                // drop points outside the extent straight to the result
                n_state = i_sts.in_extent ? S_MUL : S_WB;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_INDEX;
            end
            S_INDEX: begin
                o_cmd.index = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WB;
            end
            S_WB: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.wb = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep_rsp <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_rsp <= n_sweep_rsp;
        end
    end

endmodule

FILE: rtl/core/lpog_dp.sv
// Datapath: coordinate binning, cell store and result register.
module lpog_dp import lpog_pkg::*; #(
    parameter int HALF_CELLS = HALF_CELLS_DEF,
    parameter int CELL_MM    = CELL_MM_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    lpog_in_if.sink       i_in,
    lpog_out_if.source    o_out
);

    localparam int SIDE   = 2 * HALF_CELLS + 1;
    localparam int CELLS  = SIDE * SIDE;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int CO_W   = $clog2(SIDE);
    localparam int LIM    = HALF_CELLS * CELL_MM;
    localparam int DIV    = 2 * CELL_MM;
    localparam int OFS    = SIDE * CELL_MM;
    localparam int NU_W   = $clog2(2 * LIM + OFS + 1);
    localparam int SH     = NU_W + $clog2(DIV);
    localparam longint RECIP = ((longint'(1) <<< SH) + longint'(DIV) - 1) / longint'(DIV);
    localparam int RC_W   = NU_W + 2;
    localparam int PR_W   = NU_W + RC_W;
    localparam int LB_W   = $clog2(LIM + 1) + 2;
    localparam int SX_W   = (LB_W > COORD_W + 1) ? LB_W : COORD_W + 1;
    localparam int SM_W   = ((SX_W > NU_W) ? SX_W : NU_W) + 2;
    localparam int CMP_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

    localparam logic signed [SX_W-1:0] LIM_S   = SX_W'(LIM);
    localparam logic [RC_W-1:0]        RECIP_V = RC_W'(RECIP);

    // input hold
    logic                      take_in;
    t_cmd                      r_cmd;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [ADDR_W-1:0]         r_ridx;
    logic                      r_rd_ok;

    // binning pipeline
    logic                      r_inside;
    logic [NU_W-1:0]           r_num_x, r_num_y;
    logic [PR_W-1:0]           r_prod_x, r_prod_y;
    logic [IDX_W-1:0]          r_idx;

    // store
    t_code                     mem [CELLS];
    t_code                     r_rdata;
    logic [IDX_W-1:0]          r_sweep;

    // result register
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic [ADDR_W-1:0]         r_out_addr;
    logic                      r_out_drop;

    logic signed [SX_W-1:0]    x_w, y_w;
    logic                      in_extent;
    logic signed [SM_W-1:0]    num_x, num_y;
    logic [CO_W-1:0]           col, row;
    logic [IDX_W-1:0]          idx;
    logic [IDX_W-1:0]          rd_addr;
    logic                      sweep_last;
    logic                      out_free;
    logic                      is_point;
    t_code                     new_code;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    t_code                     mem_wdata;
    logic signed [VALUE_W-1:0] res_value;
    logic [ADDR_W-1:0]         res_addr;
    logic                      res_drop;

    assign take_in    = i_cmd.in_rdy && i_in.valid;
    assign i_in.ready = i_cmd.in_rdy;

    // range check and scaled coordinate: 2*c + SIDE*CELL_MM
    assign x_w       = SX_W'(r_x);
    assign y_w       = SX_W'(r_y);
    assign in_extent = (x_w >= -LIM_S) && (x_w <= LIM_S) && (y_w >= -LIM_S) && (y_w <= LIM_S);
    assign num_x     = (SM_W'(r_x) <<< 1) + SM_W'(OFS);
    assign num_y     = (SM_W'(r_y) <<< 1) + SM_W'(OFS);

    // floor(num / (2*CELL_MM)) by reciprocal multiply
    assign col = r_prod_x[SH +: CO_W];
    assign row = r_prod_y[SH +: CO_W];
    assign idx = IDX_W'(IDX_W'(row) * IDX_W'(SIDE)) + IDX_W'(col);

    assign rd_addr    = (r_cmd == CMD_READ) ? IDX_W'(r_ridx) : r_idx;
    assign sweep_last = (r_sweep == IDX_W'(CELLS - 1));
    assign out_free   = !r_out_valid || o_out.ready;
    assign is_point   = (r_cmd == CMD_GRASS) || (r_cmd == CMD_ROAD);

    // road wins over grass in either arrival order
    assign new_code = ((r_cmd == CMD_ROAD) || (r_rdata == CELL_ROAD)) ? CELL_ROAD : CELL_GRASS;

    always_comb begin
        res_value = VAL_UNKNOWN;
        res_addr  = '0;
        res_drop  = 1'b0;
        unique case (r_cmd) inside
            CMD_READ: begin
                res_addr = r_ridx;
                if (r_rd_ok) begin
                    res_value = code_value(r_rdata);
                end
            end
            CMD_GRASS, CMD_ROAD: begin
                if (r_inside) begin
                    res_value = code_value(new_code);
                    res_addr  = ADDR_W'(r_idx);
                end else begin
                    res_drop = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = new_code;
        if (i_cmd.sweep_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep;
            mem_wdata = CELL_UNKNOWN;
        end else if (i_cmd.wb && is_point && r_inside) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_cmd   <= i_in.cmd;
            r_x     <= i_in.point_x_mm;
            r_y     <= i_in.point_y_mm;
            r_ridx  <= i_in.read_index;
            r_rd_ok <= CMP_W'(i_in.read_index) < CMP_W'(CELLS);
        end
        if (i_cmd.coord) begin
            r_inside <= in_extent;
            r_num_x  <= num_x[NU_W-1:0];
            r_num_y  <= num_y[NU_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod_x <= PR_W'(r_num_x) * PR_W'(RECIP_V);
            r_prod_y <= PR_W'(r_num_y) * PR_W'(RECIP_V);
        end
        if (i_cmd.index) begin
            r_idx <= idx;
        end
        if (i_cmd.wb) begin
            r_out_value <= res_value;
            r_out_addr  <= res_addr;
            r_out_drop  <= res_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep_step) begin
                r_sweep <= sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_cmd.wb) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.cell_value    = r_out_value;
    assign o_out.cell_addr     = r_out_addr;
    assign o_out.point_dropped = r_out_drop;

    always_comb begin
        o_sts            = '0;
        o_sts.in_valid   = i_in.valid;
        o_sts.in_clear   = (i_in.cmd == CMD_CLEAR);
        o_sts.in_read    = (i_in.cmd == CMD_READ);
        o_sts.in_extent  = in_extent;
        o_sts.sweep_last = sweep_last;
        o_sts.out_free   = out_free;
    end

endmodule

FILE: rtl/core/labeled_point_occupancy_grid_core.sv
// Occupancy grid that bins grass and road points into a square cell store.
// A grid of (2*HALF_CELLS+1)^2 cells (111 x 111 by default) is kept in a single-port
// store of 2-bit codes. Commands arrive one at a time on the input channel and each gives
// one result on the output channel; the result register lets the next command enter while
// a result waits. A grass or road point passes through range check, reciprocal multiply
// for row and column, index multiply-add, cell read and cell update; a cell read goes
// through the cell read and the result write, and a point outside the extent goes from
// the range check straight to the result. A clear walks the store one cell per cycle
// and then writes its result; after reset the same walk runs before the first command
// is taken.
module labeled_point_occupancy_grid_core import lpog_pkg::*; #(
    parameter int HALF_CELLS = HALF_CELLS_DEF,
    parameter int CELL_MM    = CELL_MM_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpog_in_if.sink    i_in,
    lpog_out_if.source o_out
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    lpog_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    lpog_dp #(
        .HALF_CELLS (HALF_CELLS),
        .CELL_MM    (CELL_MM)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
